// ----- rtl/core/round_robin_user_step_scheduler_macros.svh -----
// ----------------------------------------------------------------------------
// Round-robin user step scheduler: assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_USER_STEP_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_USER_STEP_SCHEDULER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define RRUS_ASSERT_IMPLY(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("rrus: same-cycle check failed");
// next-cycle implication
`define RRUS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("rrus: next-cycle check failed");
`else
`define RRUS_ASSERT_IMPLY(name, clk_s, rst_s, ante, cons)
`define RRUS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons)
`endif

`endif

// ----- rtl/core/rrus_pkg.sv -----
// ----------------------------------------------------------------------------
// rrus_pkg
// Shared types and constants of the round-robin user step scheduler.
// ----------------------------------------------------------------------------
package rrus_pkg;

  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;
  localparam int SLOT_FW        = 6;
  localparam int STEP_FW        = 6;
  localparam int CNT_W          = 32;
  localparam int ROW_W          = 16;
  localparam int LIVE_W         = 7;
  localparam int SCNT_W         = 7;
  localparam int STEPS_W        = 7;

  localparam int SLOT_COUNT_RST = 10;
  localparam int STEPS_RST      = 1;

  localparam logic CMD_PICK = 1'b0;
  localparam logic CMD_DONE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT_COUNT = 2'd0,
    CFG_STEPS      = 2'd1,
    CFG_ITER_CAP   = 2'd2,
    CFG_ROW_COUNT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic               cmd;
    logic [SLOT_FW-1:0] slot_in;
    logic               failed;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [SLOT_FW-1:0] slot_out;
    logic [STEP_FW-1:0] step_out;
    logic [CNT_W-1:0]   iteration_out;
    logic [ROW_W-1:0]   row_out;
    logic [LIVE_W-1:0]  live_slots;
    logic [CNT_W-1:0]   started_total;
    logic [CNT_W-1:0]   executed_total;
    logic [CNT_W-1:0]   failed_total;
    logic [CNT_W-1:0]   finished_total;
    logic [CNT_W-1:0]   abandoned_total;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // latch word, scan, read table
    logic scan;     // rescan after a retirement, read table
    logic eval;     // apply update, load result
    logic cfg_we;   // config write
    logic reload;   // one step of the live-count sweep
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic retire;        // current eval retires a slot, no result
    logic cfg_is_slots;  // pending config write targets slot_count
    logic reload_last;   // sweep at its last slot
  } ctl_sts_t;

endpackage

// ----- rtl/core/rrus_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrus_ctrl
// Sequencer: accept, evaluate, rescan after retirement, live-count sweep.
// ----------------------------------------------------------------------------
module rrus_ctrl import rrus_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  output ctl_cmd_t cmd,
  input  ctl_sts_t sts
);

  typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_SCAN, ST_RELOAD} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // nothing is taken while reset is held
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign cfg_ready = (state_r == ST_IDLE) && rst_n;
  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid && rst_n;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_we = 1'b1;
          if (sts.cfg_is_slots) begin
            state_nxt = ST_RELOAD;
          end
        end else if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          cmd.eval = 1'b1;
          if (sts.retire) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_RELOAD: begin
        cmd.reload = 1'b1;
        if (sts.reload_last) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/core/rrus_dpath.sv -----
// ----------------------------------------------------------------------------
// rrus_dpath
// Slot table, rotating priority scan, counters, config and result registers.
// ----------------------------------------------------------------------------
module rrus_dpath import rrus_pkg::*; #(
  parameter int MAX_SLOTS = 64,
  parameter int MAX_STEPS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_cmd_t              cmd,
  output ctl_sts_t              sts,
  input  in_item_t              in_data,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output out_item_t             out_data
);

  localparam int SW       = $clog2(MAX_SLOTS);
  localparam int NW       = $clog2(MAX_SLOTS + 1);
  localparam int STW      = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int LIVE_RST = (SLOT_COUNT_RST > MAX_SLOTS) ? MAX_SLOTS : SLOT_COUNT_RST;

  // config
  logic [SCNT_W-1:0]  slot_count_r;
  logic [STEPS_W-1:0] steps_r;
  logic [CNT_W-1:0]   cap_r;
  logic [ROW_W-1:0]   row_count_r;

  // control state
  logic [SW-1:0]        cursor_r, cursor_nxt;
  logic [ROW_W-1:0]     row_cur_r, row_cur_nxt;
  logic [MAX_SLOTS-1:0] busy_r, ret_r, ent_vld_r;
  logic [LIVE_W-1:0]    live_r, live_nxt;
  logic [CNT_W-1:0]     started_r, started_nxt;
  logic [CNT_W-1:0]     exec_r, exec_nxt;
  logic [CNT_W-1:0]     fail_cnt_r, fail_cnt_nxt;
  logic [CNT_W-1:0]     fin_r, fin_nxt;
  logic [CNT_W-1:0]     aband_r, aband_nxt;
  logic [NW-1:0]        sweep_r;

  // per-item latches
  logic               op_r;
  logic [SLOT_FW-1:0] sin_r;
  logic               fail_r;
  logic               found_r;
  logic [SW-1:0]      idx_r;
  logic [SW-1:0]      start_r;

  // slot table, one read port with registered data
  logic [STW-1:0]   mem_step [MAX_SLOTS];
  logic [CNT_W-1:0] mem_iter [MAX_SLOTS];
  logic [ROW_W-1:0] mem_row  [MAX_SLOTS];
  logic [STW-1:0]   rd_step_r;
  logic [CNT_W-1:0] rd_iter_r;
  logic [ROW_W-1:0] rd_row_r;
  logic             rd_vld_r;
  logic [SW-1:0]    rd_addr;

  logic [NW-1:0]        used_n;
  logic [STEPS_W-1:0]   used_s;
  logic [MAX_SLOTS-1:0] rdy, rdy_hi, pick_vec, iso;
  logic                 scan_found;
  logic [SW-1:0]        scan_idx;
  logic [SW-1:0]        start_nrm;

  logic [STW-1:0]   e_step;
  logic [CNT_W-1:0] e_iter;
  logic [ROW_W-1:0] e_row;
  logic             is_pick, step0, cap_hit, retire, done_ok, last;
  logic [SW-1:0]    sin_idx, cur_adv;
  logic [ROW_W-1:0] row_base, row_adv;
  logic [STW-1:0]   nstep;
  logic [CNT_W-1:0] niter;

  logic             mem_we;
  logic [SW-1:0]    mem_addr;
  logic [STW-1:0]   w_step;
  logic [CNT_W-1:0] w_iter;
  logic [ROW_W-1:0] w_row;
  logic             busy_set, busy_clr, ret_set;
  out_item_t        res, out_r;

  assign out_data = out_r;

  // clamped config
  always_comb begin
    if (slot_count_r == '0) begin
      used_n = NW'(1);
    end else if (32'(slot_count_r) > 32'(MAX_SLOTS)) begin
      used_n = NW'(MAX_SLOTS);
    end else begin
      used_n = NW'(slot_count_r);
    end
    if (steps_r == '0) begin
      used_s = STEPS_W'(1);
    end else if (32'(steps_r) > 32'(MAX_STEPS)) begin
      used_s = STEPS_W'(MAX_STEPS);
    end else begin
      used_s = steps_r;
    end
  end

  // rotating priority scan: first ready slot at or after the cursor, else from 0
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      rdy[i]    = !busy_r[i] && !ret_r[i] && (NW'(i) < used_n);
      rdy_hi[i] = rdy[i] && (SW'(i) >= cursor_r);
    end
    pick_vec   = (|rdy_hi) ? rdy_hi : rdy;
    iso        = pick_vec & (~pick_vec + 1'b1);
    scan_found = |rdy;
    scan_idx   = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      scan_idx = scan_idx | (iso[i] ? SW'(i) : '0);
    end
  end

  assign start_nrm = (NW'(cursor_r) >= used_n) ? '0 : cursor_r;
  assign rd_addr   = (cmd.accept && (in_data.cmd == CMD_DONE)) ?
                     SW'(in_data.slot_in) : scan_idx;

  // entry as read, never-written entries read as zero
  assign e_step = rd_vld_r ? rd_step_r : '0;
  assign e_iter = rd_vld_r ? rd_iter_r : '0;
  assign e_row  = rd_vld_r ? rd_row_r  : '0;

  assign is_pick = (op_r == CMD_PICK);
  assign step0   = (e_step == '0);
  assign cap_hit = (cap_r != '0) && (started_r >= cap_r);
  assign retire  = is_pick && found_r && step0 && cap_hit;
  assign sin_idx = SW'(sin_r);
  assign done_ok = (32'(sin_r) < 32'(MAX_SLOTS)) && busy_r[sin_idx];
  assign cur_adv = ((NW'(idx_r) + NW'(1)) >= used_n) ? '0 : idx_r + SW'(1);

  assign row_base = (row_cur_r >= row_count_r) ? '0 : row_cur_r;
  assign row_adv  = ((17'(row_base) + 17'd1) >= 17'(row_count_r)) ? '0 : row_base + 16'd1;

  assign last  = (9'(e_step) + 9'd1) >= 9'(used_s);
  assign nstep = (fail_r || last) ? '0 : e_step + STW'(1);
  assign niter = (fail_r || last) ? e_iter + 32'd1 : e_iter;

  assign sts.retire       = retire;
  assign sts.cfg_is_slots = (cfg_reg_t'(cfg_index) == CFG_SLOT_COUNT);
  assign sts.reload_last  = (sweep_r == (used_n - NW'(1)));

  always_comb begin
    started_nxt  = started_r;
    exec_nxt     = exec_r;
    fail_cnt_nxt = fail_cnt_r;
    fin_nxt      = fin_r;
    aband_nxt    = aband_r;
    live_nxt     = live_r;
    cursor_nxt   = cursor_r;
    row_cur_nxt  = row_cur_r;
    mem_we       = 1'b0;
    mem_addr     = idx_r;
    w_step       = e_step;
    w_iter       = e_iter;
    w_row        = e_row;
    busy_set     = 1'b0;
    busy_clr     = 1'b0;
    ret_set      = 1'b0;
    res          = '0;
    if (is_pick) begin
      if (!found_r) begin
        cursor_nxt = start_r;
      end else if (retire) begin
        ret_set    = 1'b1;
        live_nxt   = (live_r != '0) ? live_r - 7'd1 : '0;
        cursor_nxt = cur_adv;
      end else begin
        busy_set          = 1'b1;
        cursor_nxt        = cur_adv;
        res.accepted      = 1'b1;
        res.slot_out      = SLOT_FW'(idx_r);
        res.step_out      = STEP_FW'(e_step);
        res.iteration_out = e_iter;
        res.row_out       = e_row;
        if (step0) begin
          started_nxt = started_r + 32'd1;
          if (row_count_r != '0) begin
            row_cur_nxt = row_adv;
            mem_we      = 1'b1;
            w_row       = row_base;
            res.row_out = row_base;
          end
        end
      end
    end else begin
      mem_addr     = sin_idx;
      res.slot_out = sin_r;
      if (done_ok) begin
        exec_nxt = exec_r + 32'd1;
        if (fail_r) begin
          fail_cnt_nxt = fail_cnt_r + 32'd1;
        end
        if (last) begin
          fin_nxt = fin_r + 32'd1;
        end else if (fail_r) begin
          aband_nxt = aband_r + 32'd1;
        end
        mem_we            = 1'b1;
        w_step            = nstep;
        w_iter            = niter;
        busy_clr          = 1'b1;
        res.accepted      = 1'b1;
        res.step_out      = STEP_FW'(nstep);
        res.iteration_out = niter;
        res.row_out       = e_row;
      end
    end
    res.live_slots      = live_nxt;
    res.started_total   = started_nxt;
    res.executed_total  = exec_nxt;
    res.failed_total    = fail_cnt_nxt;
    res.finished_total  = fin_nxt;
    res.abandoned_total = aband_nxt;
  end

  // control state and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= SCNT_W'(SLOT_COUNT_RST);
      steps_r      <= STEPS_W'(STEPS_RST);
      cap_r        <= '0;
      row_count_r  <= '0;
      cursor_r     <= '0;
      row_cur_r    <= '0;
      busy_r       <= '0;
      ret_r        <= '0;
      ent_vld_r    <= '0;
      live_r       <= LIVE_W'(LIVE_RST);
      started_r    <= '0;
      exec_r       <= '0;
      fail_cnt_r   <= '0;
      fin_r        <= '0;
      aband_r      <= '0;
      sweep_r      <= '0;
    end else begin
      if (cmd.cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_SLOT_COUNT: begin
            slot_count_r <= cfg_data[SCNT_W-1:0];
            live_r       <= '0;
            sweep_r      <= '0;
          end
          CFG_STEPS:     steps_r     <= cfg_data[STEPS_W-1:0];
          CFG_ITER_CAP:  cap_r       <= cfg_data[CNT_W-1:0];
          CFG_ROW_COUNT: row_count_r <= cfg_data[ROW_W-1:0];
        endcase
      end
      if (cmd.reload) begin
        live_r  <= live_r + LIVE_W'(!ret_r[sweep_r[SW-1:0]]);
        sweep_r <= sweep_r + NW'(1);
      end
      if (cmd.eval) begin
        cursor_r   <= cursor_nxt;
        row_cur_r  <= row_cur_nxt;
        live_r     <= live_nxt;
        started_r  <= started_nxt;
        exec_r     <= exec_nxt;
        fail_cnt_r <= fail_cnt_nxt;
        fin_r      <= fin_nxt;
        aband_r    <= aband_nxt;
        if (busy_set) begin
          busy_r[idx_r] <= 1'b1;
        end
        if (busy_clr) begin
          busy_r[sin_idx] <= 1'b0;
        end
        if (ret_set) begin
          ret_r[idx_r] <= 1'b1;
        end
        if (mem_we) begin
          ent_vld_r[mem_addr] <= 1'b1;
        end
      end
    end
  end

  // payload: latches, table, result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_data.cmd;
      sin_r   <= in_data.slot_in;
      fail_r  <= in_data.failed;
      start_r <= start_nrm;
    end
    if (cmd.accept || cmd.scan) begin
      found_r   <= scan_found;
      idx_r     <= scan_idx;
      rd_step_r <= mem_step[rd_addr];
      rd_iter_r <= mem_iter[rd_addr];
      rd_row_r  <= mem_row[rd_addr];
      rd_vld_r  <= ent_vld_r[rd_addr];
    end
    if (cmd.eval && mem_we) begin
      mem_step[mem_addr] <= w_step;
      mem_iter[mem_addr] <= w_iter;
      mem_row[mem_addr]  <= w_row;
    end
    if (cmd.eval && !retire) begin
      out_r <= res;
    end
  end

endmodule

// ----- rtl/core/round_robin_user_step_scheduler.sv -----
// ----------------------------------------------------------------------------
// round_robin_user_step_scheduler
// Usage:
//   in_*  : one word per command, pick (round-robin search for a free slot)
//           or completion (frees a busy slot, advances or ends its iteration).
//   out_* : exactly one result word per command, in command order.
//   cfg_* : register writes (slot count, steps, iteration cap, row count),
//           to be issued only while no command is in flight.
// Timing: a command is accepted (with scan and table read), then evaluated
//   (table write); a pick rescans and evaluates once more for every slot that it
//   retires at the iteration cap; the single read port of the slot table
//   sets this. The result appears in the cycle after evaluation.
// Writing slot_count starts a sweep over the slots in use that
//   recounts live slots; both ready lines stay low meanwhile.
// Reset: config returns to its defaults, all slots free and unretired,
//   counters zero, live count equals the clamped default slot count.
// Stall: a waiting result sits in the output register; the next command is
//   still taken, and its evaluation holds until that register is drained.
// ----------------------------------------------------------------------------
`include "round_robin_user_step_scheduler_macros.svh"

module round_robin_user_step_scheduler import rrus_pkg::*; #(
  parameter int MAX_SLOTS = 64,
  parameter int MAX_STEPS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  // result words
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // sequencer
  rrus_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // slot table, scan and counters
  rrus_dpath #(
    .MAX_SLOTS (MAX_SLOTS),
    .MAX_STEPS (MAX_STEPS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

  // a taken command blocks the input until it is evaluated
  `RRUS_ASSERT_NEXT(a_in_busy, clk, rst_n, in_valid && in_ready, !in_ready)
  // an evaluation that does not retire always lands a result
  `RRUS_ASSERT_NEXT(a_eval_out, clk, rst_n, cmd.eval && !sts.retire, out_valid)
  // a retirement is always followed by a rescan
  `RRUS_ASSERT_NEXT(a_retire_scan, clk, rst_n, cmd.eval && sts.retire, cmd.scan)
  // live count never exceeds the table size
  `RRUS_ASSERT_IMPLY(a_live_max, clk, rst_n, out_valid, 32'(out_data.live_slots) <= 32'(MAX_SLOTS))

endmodule
